// ===== design/mcts_pkg.sv =====
// ----------------------------------------------------------------------------
// mcts_pkg: shared types and constants of the mini C token scanner
// Token kind codes, character codes, keyword lookup and the result record.
// ----------------------------------------------------------------------------
package mcts_pkg;

  // token kinds
  localparam logic [4:0] KIND_IDENT    = 5'd0;
  localparam logic [4:0] KIND_KW_INT   = 5'd1;
  localparam logic [4:0] KIND_KW_BOOL  = 5'd2;
  localparam logic [4:0] KIND_KW_FLOAT = 5'd3;
  localparam logic [4:0] KIND_KW_VOID  = 5'd4;
  localparam logic [4:0] KIND_KW_EXTERN = 5'd5;
  localparam logic [4:0] KIND_KW_IF    = 5'd6;
  localparam logic [4:0] KIND_KW_ELSE  = 5'd7;
  localparam logic [4:0] KIND_KW_WHILE = 5'd8;
  localparam logic [4:0] KIND_KW_RETURN = 5'd9;
  localparam logic [4:0] KIND_BOOL_LIT = 5'd10;
  localparam logic [4:0] KIND_INT_LIT  = 5'd11;
  localparam logic [4:0] KIND_FLOAT_LIT = 5'd12;
  localparam logic [4:0] KIND_ASSIGN   = 5'd13;
  localparam logic [4:0] KIND_EQ       = 5'd14;
  localparam logic [4:0] KIND_LBRACE   = 5'd15;
  localparam logic [4:0] KIND_RBRACE   = 5'd16;
  localparam logic [4:0] KIND_LPAREN   = 5'd17;
  localparam logic [4:0] KIND_RPAREN   = 5'd18;
  localparam logic [4:0] KIND_SEMI     = 5'd19;
  localparam logic [4:0] KIND_COMMA    = 5'd20;
  localparam logic [4:0] KIND_AND      = 5'd21;
  localparam logic [4:0] KIND_OR       = 5'd22;
  localparam logic [4:0] KIND_NOT      = 5'd23;
  localparam logic [4:0] KIND_NE       = 5'd24;
  localparam logic [4:0] KIND_LT       = 5'd25;
  localparam logic [4:0] KIND_LE       = 5'd26;
  localparam logic [4:0] KIND_GT       = 5'd27;
  localparam logic [4:0] KIND_GE       = 5'd28;
  localparam logic [4:0] KIND_DIV      = 5'd29;
  localparam logic [4:0] KIND_INVALID  = 5'd30;
  localparam logic [4:0] KIND_EOF      = 5'd31;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [15:0] FIELD_MAX = 16'hFFFF;
  localparam int unsigned KW_MAX_LEN = 6;

  // one result record
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_t;

  // identifier text (packed, last byte lowest) to kind
  function automatic logic [4:0] keyword_kind(input logic [47:0] text);
    logic [4:0] k;
    case (text)
      48'h0000_0069_6E74: k = KIND_KW_INT;
      48'h0000_626F_6F6C: k = KIND_KW_BOOL;
      48'h0066_6C6F_6174: k = KIND_KW_FLOAT;
      48'h0000_766F_6964: k = KIND_KW_VOID;
      48'h6578_7465_726E: k = KIND_KW_EXTERN;
      48'h0000_0000_6966: k = KIND_KW_IF;
      48'h0000_656C_7365: k = KIND_KW_ELSE;
      48'h0077_6869_6C65: k = KIND_KW_WHILE;
      48'h7265_7475_726E: k = KIND_KW_RETURN;
      48'h0000_7472_7565: k = KIND_BOOL_LIT;
      48'h0066_616C_7365: k = KIND_BOOL_LIT;
      default:            k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== design/mcts_core.sv =====
// ----------------------------------------------------------------------------
// mcts_core: scanner state and per-byte step logic
// Holds the scan state and counters, and forms up to two tokens per byte.
// ----------------------------------------------------------------------------
module mcts_core
  import mcts_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] ch,
  input  logic       eoi,
  output tok_t       res0,
  output tok_t       res1,
  output logic [1:0] res_cnt
);

  localparam int unsigned CW = COUNTER_BITS;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_INT     = 4'd2,
    MODE_FRAC    = 4'd3,
    MODE_SLASH   = 4'd4,
    MODE_EQ      = 4'd5,
    MODE_AMP     = 4'd6,
    MODE_BAR     = 4'd7,
    MODE_BANG    = 4'd8,
    MODE_LT      = 4'd9,
    MODE_GT      = 4'd10,
    MODE_COMMENT = 4'd11
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [47:0]   prefix_r, prefix_nxt;
  logic          kw_ok_r, kw_ok_nxt;
  logic [15:0]   pend_r, pend_nxt;
  logic [CW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] clamp16(input logic [CW-1:0] v);
    logic [CW+15:0] ext;
    ext = {16'd0, v};
    return (|ext[CW+15:16]) ? FIELD_MAX : ext[15:0];
  endfunction

  function automatic tok_t make_tok(input logic [4:0] kind, input logic [CW-1:0] line,
                                    input logic [CW-1:0] col, input logic [15:0] len);
    tok_t t;
    t.kind = kind;
    t.line = clamp16(line);
    t.col  = clamp16(col);
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  // byte classes
  logic is_alpha, is_digit, is_nl, is_space, is_word;
  assign is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
  assign is_nl    = (ch == CH_LF) || (ch == CH_CR);
  assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_word  = is_alpha || is_digit || (ch == CH_UNDER);

  logic [CW-1:0] col_inc;
  logic [15:0]   pend_ext;
  assign col_inc  = cnt_inc(col_r);
  assign pend_ext = (pend_r != FIELD_MAX) ? pend_r + 16'd1 : pend_r;

  // paired operator tables
  logic       in_pair;
  logic [7:0] pair_second;
  logic [4:0] pair_single, pair_double;

  always_comb begin
    in_pair     = 1'b1;
    pair_second = CH_EQUAL;
    pair_single = KIND_INVALID;
    pair_double = KIND_INVALID;
    case (mode_r)
      MODE_EQ: begin
        pair_single = KIND_ASSIGN;
        pair_double = KIND_EQ;
      end
      MODE_AMP: begin
        pair_second = CH_AMP;
        pair_double = KIND_AND;
      end
      MODE_BAR: begin
        pair_second = CH_BAR;
        pair_double = KIND_OR;
      end
      MODE_BANG: begin
        pair_single = KIND_NOT;
        pair_double = KIND_NE;
      end
      MODE_LT: begin
        pair_single = KIND_LT;
        pair_double = KIND_LE;
      end
      MODE_GT: begin
        pair_single = KIND_GT;
        pair_double = KIND_GE;
      end
      default: in_pair = 1'b0;
    endcase
  end

  // token left pending by the current mode
  logic flush_vld;
  tok_t flush_tok;

  always_comb begin
    flush_vld = 1'b1;
    flush_tok = make_tok(KIND_DIV, line_r, col_r, 16'd1);
    case (mode_r)
      MODE_IDENT: flush_tok = make_tok(kw_ok_r ? keyword_kind(prefix_r) : KIND_IDENT,
                                       line_r, col_r, pend_r);
      MODE_INT:   flush_tok = make_tok(KIND_INT_LIT, line_r, col_r, pend_r);
      MODE_FRAC:  flush_tok = make_tok(KIND_FLOAT_LIT, line_r, col_r, pend_r);
      MODE_SLASH: flush_tok = make_tok(KIND_DIV, line_r, col_r, 16'd1);
      MODE_EQ, MODE_AMP, MODE_BAR, MODE_BANG, MODE_LT, MODE_GT:
        flush_tok = make_tok(pair_single, line_r, col_r, 16'd1);
      default:    flush_vld = 1'b0;
    endcase
  end

  // single-byte token started from idle
  logic [4:0] byte_kind;

  always_comb begin
    case (ch)
      CH_LBRACE: byte_kind = KIND_LBRACE;
      CH_RBRACE: byte_kind = KIND_RBRACE;
      CH_LPAREN: byte_kind = KIND_LPAREN;
      CH_RPAREN: byte_kind = KIND_RPAREN;
      CH_SEMI:   byte_kind = KIND_SEMI;
      CH_COMMA:  byte_kind = KIND_COMMA;
      default:   byte_kind = KIND_INVALID;
    endcase
  end

  tok_t eof_tok, byte_tok;
  logic byte_emit;
  assign eof_tok  = make_tok(KIND_EOF, line_r, col_inc, 16'd0);
  assign byte_tok = make_tok(byte_kind, line_r, col_inc, 16'd1);

  always_comb begin
    mode_nxt   = mode_r;
    prefix_nxt = prefix_r;
    kw_ok_nxt  = kw_ok_r;
    pend_nxt   = pend_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    res0       = flush_tok;
    res1       = eof_tok;
    res_cnt    = 2'd0;
    byte_emit  = 1'b0;

    if (eoi) begin
      mode_nxt = MODE_IDLE;
      pend_nxt = 16'd0;
      if (flush_vld) begin
        res_cnt = 2'd2;
      end else begin
        res0    = eof_tok;
        res_cnt = 2'd1;
      end
    end else if (mode_r == MODE_IDENT && is_word) begin
      pend_nxt = pend_ext;
      col_nxt  = col_inc;
      if (pend_ext > 16'(KW_MAX_LEN)) begin
        kw_ok_nxt = 1'b0;
      end else begin
        prefix_nxt = {prefix_r[39:0], ch};
      end
    end else if (mode_r == MODE_INT && (is_digit || ch == CH_DOT)) begin
      pend_nxt = pend_ext;
      col_nxt  = col_inc;
      if (ch == CH_DOT) begin
        mode_nxt = MODE_FRAC;
      end
    end else if (mode_r == MODE_FRAC && is_digit) begin
      pend_nxt = pend_ext;
      col_nxt  = col_inc;
    end else if (mode_r == MODE_SLASH && ch == CH_SLASH) begin
      col_nxt  = col_inc;
      mode_nxt = MODE_COMMENT;
      pend_nxt = 16'd0;
    end else if (mode_r == MODE_COMMENT && !is_nl) begin
      col_nxt = col_inc;
    end else if (in_pair && ch == pair_second) begin
      col_nxt  = col_inc;
      mode_nxt = MODE_IDLE;
      pend_nxt = 16'd0;
      res0     = make_tok(pair_double, line_r, col_inc, 16'd2);
      res_cnt  = 2'd1;
    end else begin
      // close any pending token, then treat the byte as a fresh start
      mode_nxt = MODE_IDLE;
      pend_nxt = 16'd0;
      if (is_space) begin
        if (is_nl) begin
          line_nxt = cnt_inc(line_r);
          col_nxt  = '0;
        end else begin
          col_nxt = col_inc;
        end
      end else begin
        col_nxt  = col_inc;
        pend_nxt = 16'd1;
        if (is_alpha || ch == CH_UNDER) begin
          mode_nxt   = MODE_IDENT;
          prefix_nxt = {40'd0, ch};
          kw_ok_nxt  = 1'b1;
        end else if (is_digit) begin
          mode_nxt = MODE_INT;
        end else if (ch == CH_DOT) begin
          mode_nxt = MODE_FRAC;
        end else if (ch == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else if (ch == CH_EQUAL) begin
          mode_nxt = MODE_EQ;
        end else if (ch == CH_AMP) begin
          mode_nxt = MODE_AMP;
        end else if (ch == CH_BAR) begin
          mode_nxt = MODE_BAR;
        end else if (ch == CH_BANG) begin
          mode_nxt = MODE_BANG;
        end else if (ch == CH_LESS) begin
          mode_nxt = MODE_LT;
        end else if (ch == CH_GREATER) begin
          mode_nxt = MODE_GT;
        end else begin
          pend_nxt  = 16'd0;
          byte_emit = 1'b1;
        end
      end
      if (flush_vld && byte_emit) begin
        res1    = byte_tok;
        res_cnt = 2'd2;
      end else if (flush_vld) begin
        res_cnt = 2'd1;
      end else if (byte_emit) begin
        res0    = byte_tok;
        res_cnt = 2'd1;
      end
    end

    // mark the final token of this byte
    if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      prefix_r <= '0;
      kw_ok_r  <= 1'b0;
      pend_r   <= '0;
      line_r   <= '0;
      col_r    <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      prefix_r <= prefix_nxt;
      kw_ok_r  <= kw_ok_nxt;
      pend_r   <= pend_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
    end
  end

endmodule

// ===== design/mini_c_token_scanner.sv =====
// ----------------------------------------------------------------------------
// mini_c_token_scanner: byte-stream scanner for a small C subset
// Turns source bytes into tokens with line, end column and length.
// ----------------------------------------------------------------------------
// usage
//   input channel: one request per source byte (in_ch) or an end-of-input
//   mark (in_end_of_input), taken when in_valid is high and in_stall is low
//   output channel: one token per transfer on out_*, taken when out_valid is
//   high and out_stall is low; out_last_of_run flags the last token that a
//   byte produced (a byte gives zero, one or two tokens)
//   data path: a request is captured in the input register, then stepped
//   through the scanner into a 4-entry result queue, whose head token drives
//   the outputs
//   throughput: one byte per cycle; the input stalls only while the result
//   queue holds more than two tokens, so the output side sets the pace when
//   bytes produce tokens faster than they are drained
//   reset: synchronous; scanner goes idle, line and column counters clear,
//   input register and result queue empty
//   a stalled receiver holds the head token; bytes keep flowing until the
//   queue fills
// ----------------------------------------------------------------------------
module mini_c_token_scanner
  import mcts_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_line_number,
  output logic [15:0] out_end_column,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // input register
  logic       stg_vld_r;
  logic [7:0] stg_ch_r;
  logic       stg_eoi_r;

  // result queue
  tok_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   q_cnt_r, q_cnt_nxt;

  tok_t       res0, res1;
  logic [1:0] res_cnt;
  logic       step, in_take, out_take;

  // the step may add two tokens, so it needs two free slots
  assign step     = stg_vld_r && (q_cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign in_stall = stg_vld_r && !step;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  mcts_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .ch      (stg_ch_r),
    .eoi     (stg_eoi_r),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (step) begin
      q_cnt_nxt = q_cnt_nxt + (QAW+1)'(res_cnt);
    end
    if (out_take) begin
      q_cnt_nxt = q_cnt_nxt - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_cnt_r   <= '0;
    end else begin
      if (in_take) begin
        stg_vld_r <= 1'b1;
      end else if (step) begin
        stg_vld_r <= 1'b0;
      end
      if (step) begin
        wr_ptr_r <= wr_ptr_r + QAW'(res_cnt);
      end
      if (out_take) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_ch_r  <= in_ch;
      stg_eoi_r <= in_end_of_input;
    end
    if (step && res_cnt != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (step && res_cnt == 2'd2) begin
      q_r[wr_ptr_r + QAW'(1)] <= res1;
    end
  end

  assign out_valid        = (q_cnt_r != '0);
  assign out_token_kind   = q_r[rd_ptr_r].kind;
  assign out_line_number  = q_r[rd_ptr_r].line;
  assign out_end_column   = q_r[rd_ptr_r].col;
  assign out_token_length = q_r[rd_ptr_r].len;
  assign out_last_of_run  = q_r[rd_ptr_r].last;

endmodule

// ===== design/mcts_checker.sv =====
// ----------------------------------------------------------------------------
// mcts_checker: port-level checks of the token scanner
// Watches both channels for held stalled transfers and token shapes that must always hold.
// ----------------------------------------------------------------------------
module mcts_checker
  import mcts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_ch,
  input logic        in_end_of_input,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_token_kind,
  input logic [15:0] out_line_number,
  input logic [15:0] out_end_column,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_ch) && $stable(in_end_of_input))
    else $error("stalled request changed");

  // stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind)
      && $stable(out_line_number) && $stable(out_end_column)
      && $stable(out_token_length))
    else $error("stalled token changed");

  // end of input always closes a run and has no lexeme
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_EOF |-> out_last_of_run && out_token_length == 16'd0)
    else $error("malformed eof token");

  // paired operators span two bytes
  a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_EQ || out_token_kind == KIND_AND
      || out_token_kind == KIND_OR || out_token_kind == KIND_NE
      || out_token_kind == KIND_LE || out_token_kind == KIND_GE)
      |-> out_token_length == 16'd2 && out_end_column >= 16'd2)
    else $error("paired operator length");

  // single-byte tokens
  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_DIV || out_token_kind == KIND_INVALID
      || out_token_kind == KIND_SEMI || out_token_kind == KIND_COMMA
      || out_token_kind == KIND_LPAREN || out_token_kind == KIND_RPAREN)
      |-> out_token_length == 16'd1 && out_end_column != 16'd0)
    else $error("single-byte token length");

endmodule

bind mini_c_token_scanner mcts_checker u_mcts_checker (.*);
